FILE: rtl/cgdz_pkg.sv
// ----------------------------------------------------------------------------
// cgdz_pkg
// Shared types and constants of the color gradient block.
// ----------------------------------------------------------------------------
package cgdz_pkg;

  localparam int LINE_MAX  = 2048;
  localparam int LINE_AW   = $clog2(LINE_MAX);
  localparam int CNT_W     = 11;
  localparam int FRAME_MAX = 2048;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] lab_l;
    logic [7:0] lab_a;
    logic [7:0] lab_b;
  } cgdz_in_t;

  typedef struct packed {
    logic [10:0] center_row;
    logic [10:0] center_col;
    logic [11:0] magnitude;
    logic        direction;
    logic        frame_done;
  } cgdz_out_t;

  // Window sums handed from the front end to the root unit.
  typedef struct packed {
    logic [20:0] gxx;
    logic [20:0] gyy;
    logic [20:0] gxy_abs;
    logic [10:0] row;
    logic [10:0] col;
    logic        last;
  } cgdz_grad_t;

endpackage

FILE: rtl/color_gradient_di_zenzo_unit.sv
// ----------------------------------------------------------------------------
// color_gradient_di_zenzo_unit
// Di Zenzo color gradient over a raster stream of Lab pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one Lab pixel per item, raster order, valid/ready.
//   out_* : one item per interior pixel (row, col, magnitude, direction,
//           frame_done); border pixels give no item.
//   cfg_* : register writes (0 width, 1 height); write only while no item
//           is in flight. Sizes clamp to 3..2048.
// The two line stores live in one 48-bit synchronous RAM (older, newer)
// addressed by column. An item runs: read RAM, gradient sums, squared
// terms, root start, inner root, outer root; a border pixel ends after
// the gradient sums. The serial square root unit does both roots. The
// block holds one item at a time; a waiting result sits in the output
// register and the next pixel is taken only once it leaves.
// Reset clears counters, window and control; line store contents are
// undefined until written by the first two lines of a frame.
// A stalled receiver simply holds out_valid and blocks further input.
// ----------------------------------------------------------------------------
module color_gradient_di_zenzo_unit import cgdz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cgdz_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cgdz_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [11:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_GRAD = 3'd2;
  localparam logic [2:0] ST_SQ1  = 3'd3;
  localparam logic [2:0] ST_SQ2  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;
  localparam logic [2:0] ST_ROOT = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [11:0] width_r, height_r;
  logic [10:0] col_r, row_r;
  logic [23:0] px_r;
  logic [23:0] win_r [6];
  logic [47:0] line_mem [LINE_MAX];
  logic [47:0] rd_r;
  cgdz_grad_t  grad_r;
  logic [41:0] diff2_r;
  logic [43:0] gxy4_r;
  cgdz_out_t   out_r;
  logic        out_valid_r;

  // effective clamped sizes
  logic [11:0] w_eff, h_eff;
  always_comb begin
    w_eff = (width_r < 12'd3) ? 12'd3 :
            (width_r > 12'(LINE_MAX)) ? 12'(LINE_MAX) : width_r;
    h_eff = (height_r < 12'd3) ? 12'd3 :
            (height_r > 12'(FRAME_MAX)) ? 12'(FRAME_MAX) : height_r;
  end

  logic [23:0] up, mid;
  assign up  = rd_r[47:24];
  assign mid = rd_r[23:0];

  // per-channel gradients
  logic signed [10:0] gx [3];
  logic signed [10:0] gy [3];
  logic [20:0] sxx, syy;
  logic signed [21:0] sxy;
  always_comb begin
    sxx = '0;
    syy = '0;
    sxy = '0;
    for (int k = 0; k < 3; k++) begin
      gx[k] = 11'(signed'({3'b0, px_r[8*k +: 8]}))  - 11'(signed'({3'b0, win_r[0][8*k +: 8]}))
            + 11'(signed'({3'b0, up[8*k +: 8]}))    - 11'(signed'({3'b0, win_r[4][8*k +: 8]}))
            + 11'(signed'({3'b0, mid[8*k +: 8]}))   - 11'(signed'({3'b0, win_r[2][8*k +: 8]}));
      gy[k] = 11'(signed'({3'b0, px_r[8*k +: 8]}))  - 11'(signed'({3'b0, win_r[0][8*k +: 8]}))
            - 11'(signed'({3'b0, up[8*k +: 8]}))    + 11'(signed'({3'b0, win_r[4][8*k +: 8]}))
            + 11'(signed'({3'b0, win_r[5][8*k +: 8]})) - 11'(signed'({3'b0, win_r[1][8*k +: 8]}));
      sxx = sxx + 21'(unsigned'(22'(gx[k] * gx[k])));
      syy = syy + 21'(unsigned'(22'(gy[k] * gy[k])));
      sxy = sxy + 22'(gx[k] * gy[k]);
    end
  end

  // squared terms of the inner root, one stage after the sums
  logic [20:0] dxy;
  logic [43:0] gxy4_w;
  logic [43:0] dd_sum;
  assign dxy    = (grad_r.gxx >= grad_r.gyy) ? grad_r.gxx - grad_r.gyy
                                             : grad_r.gyy - grad_r.gxx;
  assign gxy4_w = {42'(grad_r.gxy_abs * grad_r.gxy_abs), 2'b00};
  assign dd_sum = {2'b00, diff2_r} + gxy4_r;

  // square root unit, shared by both roots
  logic        sq_start, sq_done;
  logic [63:0] sq_rad;
  logic [31:0] sq_root;
  cgdz_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  logic [21:0] t_hi;
  logic [63:0] t_full;
  assign t_hi   = {1'b0, grad_r.gxx} + {1'b0, grad_r.gyy};
  assign t_full = {34'd0, t_hi, 8'd0} + {32'd0, sq_root};

  logic interior, last_px;
  assign interior = (row_r >= 11'd2) && (col_r >= 11'd2);
  assign last_px  = ({1'b0, row_r} + 12'd1 >= h_eff) && ({1'b0, col_r} + 12'd1 >= w_eff);

  logic in_acc, out_acc;
  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    sq_start  = 1'b0;
    sq_rad    = '0;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_GRAD;
      ST_GRAD: state_nxt = interior ? ST_SUM : ST_IDLE;
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        sq_start  = 1'b1;
        sq_rad    = {4'd0, dd_sum, 16'd0};
        state_nxt = ST_SQ1;
      end
      ST_SQ1: if (sq_done) begin
        sq_start  = 1'b1;
        sq_rad    = {7'd0, t_full[63:7]};
        state_nxt = ST_SQ2;
      end
      ST_SQ2: if (sq_done) state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= 12'd640;
      height_r    <= 12'd480;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
      end
      if (out_acc) out_valid_r <= 1'b0;
      if (state_r == ST_SQ2 && sq_done) out_valid_r <= 1'b1;
      if (state_r == ST_GRAD) begin
        win_r[0] <= win_r[1]; win_r[1] <= up;
        win_r[2] <= win_r[3]; win_r[3] <= mid;
        win_r[4] <= win_r[5]; win_r[5] <= px_r;
        if ({1'b0, col_r} + 12'd1 >= w_eff) begin
          col_r <= '0;
          row_r <= ({1'b0, row_r} + 12'd1 >= h_eff) ? 11'd0 : row_r + 11'd1;
        end else begin
          col_r <= col_r + 11'd1;
        end
      end
    end
    if (in_acc) px_r <= in_data;
    if (state_r == ST_IDLE) rd_r <= line_mem[col_r];
    if (state_r == ST_GRAD) begin
      line_mem[col_r] <= {mid, px_r};
      grad_r.gxx     <= sxx;
      grad_r.gyy     <= syy;
      grad_r.gxy_abs <= sxy[21] ? 21'(-sxy) : 21'(sxy);
      grad_r.row     <= row_r - 11'd1;
      grad_r.col     <= col_r - 11'd1;
      grad_r.last    <= last_px;
    end
    if (state_r == ST_SUM) begin
      diff2_r <= 42'(dxy * dxy);
      gxy4_r  <= gxy4_w;
    end
    if (state_r == ST_SQ2 && sq_done) begin
      out_r.center_row <= grad_r.row;
      out_r.center_col <= grad_r.col;
      out_r.magnitude  <= 12'((sq_root + 32'd1) >> 1);
      out_r.direction  <= (grad_r.gxx >= grad_r.gyy) ? 1'b0 : 1'b1;
      out_r.frame_done <= grad_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/cgdz_sqrt.sv
// ----------------------------------------------------------------------------
// cgdz_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cgdz_sqrt import cgdz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r, v_nxt;
  logic [31:0] res_r, res_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [33:0] trial;

  // restoring root: one result bit per cycle
  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      v_nxt    = radicand;
      res_nxt  = '0;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial   = {rem_r[31:0], v_r[63:62]} - {res_r, 2'b01};
      v_nxt   = {v_r[61:0], 2'b00};
      if (!trial[33]) begin
        rem_nxt = trial;
        res_nxt = {res_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], v_r[63:62]};
        res_nxt = {res_r[30:0], 1'b0};
      end
      step_nxt = step_r + 5'd1;
      if (step_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign root = res_r;

endmodule

FILE: rtl/cgdz_checker.sv
// ----------------------------------------------------------------------------
// cgdz_checker
// Port-level checks of the color gradient block.
// ----------------------------------------------------------------------------
module cgdz_checker import cgdz_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input cgdz_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result waits");

  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.magnitude <= 12'd2500 && out_data.center_row != 11'd0)
    else $error("result out of range");

endmodule

bind color_gradient_di_zenzo_unit cgdz_checker u_cgdz_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

FILE: verif/color_gradient_di_zenzo_unit_tb.sv
// ----------------------------------------------------------------------------
// color_gradient_di_zenzo_unit_tb
// Drives small Lab frames through the gradient block under several idle
// patterns and frame sizes, predicts every interior result and checks it.
// ----------------------------------------------------------------------------
module color_gradient_di_zenzo_unit_tb;
  import cgdz_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  cgdz_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  cgdz_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [11:0] cfg_data;

  color_gradient_di_zenzo_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: line stores, 3x3 window history, raster position.
  logic [23:0] older_px [LINE_MAX];
  logic [23:0] newer_px [LINE_MAX];
  logic [23:0] win [6];
  int unsigned col_pos, row_pos;
  int unsigned frame_w, frame_h;

  cgdz_out_t   pending_grad [$];
  int          errors;
  int          results_seen;
  int          items_sent;
  longint      cycles;

  // Idle control: percentages, plus a long receiver hold-off.
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("color_gradient_di_zenzo_unit_tb failed");
        $finish;
      end
    end
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int chan_of(logic [23:0] px, int k);
    return int'(px[8*k +: 8]);
  endfunction

  // Advance the raster model by one pixel; queue a result for interior ones.
  task automatic predict_gradient(cgdz_in_t pix);
    logic [23:0] px, up, mid;
    longint gxx, gyy, gxy, gx, gy, c1, c2, diffv, axy;
    longint unsigned dd, s, t, q;
    int unsigned w, h;
    cgdz_out_t res;
    w = (frame_w < 3) ? 3 : (frame_w > LINE_MAX ? LINE_MAX : frame_w);
    h = (frame_h < 3) ? 3 : (frame_h > 2048 ? 2048 : frame_h);
    px = {pix.lab_b, pix.lab_a, pix.lab_l};
    up = older_px[col_pos];
    mid = newer_px[col_pos];
    older_px[col_pos] = mid;
    newer_px[col_pos] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      gxx = 0; gyy = 0; gxy = 0;
      for (int k = 0; k < 3; k++) begin
        c1 = chan_of(px, k) - chan_of(win[0], k);
        c2 = chan_of(up, k) - chan_of(win[4], k);
        gx = c1 + c2 + chan_of(mid, k) - chan_of(win[2], k);
        gy = c1 - c2 + chan_of(win[5], k) - chan_of(win[1], k);
        gxx += gx * gx;
        gyy += gy * gy;
        gxy += gx * gy;
      end
      diffv = (gxx >= gyy) ? gxx - gyy : gyy - gxx;
      axy = (gxy < 0) ? -gxy : gxy;
      dd = longint'(diffv * diffv) + 4 * axy * axy;
      s = int_root(dd << 16);
      t = (longint'(gxx + gyy) << 8) + s;
      q = int_root(t >> 7);
      res.center_row = 11'(row_pos - 1);
      res.center_col = 11'(col_pos - 1);
      res.magnitude  = 12'((q + 1) >> 1);
      res.direction  = (gxx >= gyy) ? 1'b0 : 1'b1;
      res.frame_done = (row_pos + 1 >= h && col_pos + 1 >= w);
      pending_grad.push_back(res);
    end
    win[0] = win[1]; win[1] = up;
    win[2] = win[3]; win[3] = mid;
    win[4] = win[5]; win[5] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Result checker and receiver; stall chance and hold-off come from the phase.
  initial begin
    cgdz_out_t exp_res;
    out_ready = 1'b0;
    errors = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (pending_grad.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          errors++;
        end else begin
          exp_res = pending_grad.pop_front();
          if (out_data.center_row !== exp_res.center_row)
            $display("%0t: center_row exp %0d got %0d", $time,
                     exp_res.center_row, out_data.center_row);
          if (out_data.center_col !== exp_res.center_col)
            $display("%0t: center_col exp %0d got %0d", $time,
                     exp_res.center_col, out_data.center_col);
          if (out_data.magnitude !== exp_res.magnitude)
            $display("%0t: magnitude exp %0d got %0d", $time,
                     exp_res.magnitude, out_data.magnitude);
          if (out_data.direction !== exp_res.direction)
            $display("%0t: direction exp %0d got %0d", $time,
                     exp_res.direction, out_data.direction);
          if (out_data.frame_done !== exp_res.frame_done)
            $display("%0t: frame_done exp %0d got %0d", $time,
                     exp_res.frame_done, out_data.frame_done);
          if (out_data !== exp_res) errors++;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One pixel across the input handshake, with random idle before it.
  // Valid stays up after the accept; an idle in the next call or the caller drops it.
  task automatic send_pixel(cgdz_in_t pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pix;
    do @(posedge clk); while (!in_ready);
    predict_gradient(pix);
    items_sent++;
  endtask

  // Register write, only with the block drained. Border pixels may still be
  // in flight after the last result, so allow their latency first.
  task automatic write_reg(logic idx, logic [11:0] val);
    in_valid <= 1'b0;
    wait (pending_grad.size() == 0);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) frame_w = val;
    else frame_h = val;
  endtask

  function automatic cgdz_in_t rand_pixel();
    cgdz_in_t p;
    p = cgdz_in_t'(24'($urandom_range(24'hffffff)));
    return p;
  endfunction

  // Pad the current frame to its end so a size change starts a fresh frame.
  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) send_pixel(rand_pixel());
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    finish_frame();
    write_reg(CFG_WIDTH, 12'(w));
    write_reg(CFG_HEIGHT, 12'(h));
  endtask

  // Directed table: 3x3 frame rows. Flat frames have an obvious zero
  // magnitude and vertical direction; others go to the predictor.
  typedef struct {
    cgdz_in_t pix;
    logic     has_exp;
  } pix_row_t;

  pix_row_t directed_tbl [18];

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data  = '0;
    rst_n     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    items_sent     = 0;
    frame_w = 640;
    frame_h = 480;
    col_pos = 0;
    row_pos = 0;
    foreach (win[i]) win[i] = '0;
    foreach (older_px[i]) begin
      older_px[i] = '0;
      newer_px[i] = '0;
    end
    // first frame all zero, second frame all max (both give magnitude 0)
    for (int i = 0; i < 9; i++) begin
      directed_tbl[i]     = '{'0, 1'b1};
      directed_tbl[i + 9] = '{24'hffffff, 1'b1};
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame, which also covers width/height clamping below 3.
    set_frame(0, 1);
    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].has_exp && i % 9 == 8) begin
        send_pixel(directed_tbl[i].pix);
        if (pending_grad[$].magnitude !== 0 || pending_grad[$].direction !== 0 ||
            pending_grad[$].frame_done !== 1'b1 || pending_grad[$].center_row !== 1)
          begin
          $display("%0t: flat frame prediction off", $time);
          errors++;
        end
      end else begin
        send_pixel(directed_tbl[i].pix);
      end
    end
    // Extreme steps: a checkerboard, then row stripes, of 0/255 per channel, predictor checked.
    set_frame(3, 3);
    for (int i = 0; i < 9; i++)
      send_pixel(cgdz_in_t'((i % 2) ? 24'hffffff : 24'h0));
    for (int i = 0; i < 9; i++)
      send_pixel(cgdz_in_t'((i / 3 == 1) ? 24'hff00ff : 24'h00ff00));

    // Random frames across idle phases, with a long hold-off once.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      set_frame($urandom_range(3, 12), $urandom_range(3, 10));
      if (phase == 0) hold_cycles = 2000;
      for (int n = 0; n < 240; n++)
        send_pixel(rand_pixel());
    end
    // A tall narrow frame, then sizes above the range (clamped).
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_frame(3, 20);
    for (int n = 0; n < 3 * 20; n++) send_pixel(rand_pixel());
    set_frame(4095, 4095);
    for (int n = 0; n < 50; n++) send_pixel(rand_pixel());
    in_valid <= 1'b0;

    wait (pending_grad.size() == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d pixels, checked %0d gradient results", items_sent,
             results_seen);
    $display("frame sizes 3x3 up to 12 wide and 20 tall, four idle patterns");
    if (errors == 0 && pending_grad.size() == 0) begin
      $display("color_gradient_di_zenzo_unit_tb passed");
    end else begin
      $display("color_gradient_di_zenzo_unit_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cgdz_pkg.sv
rtl/cgdz_sqrt.sv
rtl/color_gradient_di_zenzo_unit.sv
rtl/cgdz_checker.sv
verif/color_gradient_di_zenzo_unit_tb.sv
